FILE: rtl/tvr_pkg.sv
`timescale 1ns / 1ps
package tvr_pkg;

    localparam int W_LOG  = 8;
    localparam int D_LOG  = 6;
    localparam int MAX_TILES = 4096;

    localparam int CW     = 20;
    localparam int SZ_W   = CW + 1;
    localparam int TXW    = CW - W_LOG;
    localparam int TZW    = CW - D_LOG;
    localparam int TNXW   = TXW + 1;
    localparam int TNZW   = TZW + 1;

    localparam int RANK_W = 12;
    localparam int OFF_W  = 22;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 3;

    localparam int TXY_W  = 2 * TNXW;
    localparam int SXY_W  = 2 * SZ_W;
    localparam int VOX_W  = ADDR_W + 1 + SZ_W;
    localparam int TIL_W  = TXY_W + TNZW;

    localparam int SETTLE = 4;
    localparam int CNT_W  = 3;

    localparam logic [ADDR_W:0] VOX_LIMIT = {1'b1, {ADDR_W{1'b0}}};

    localparam logic [IDX_W-1:0] REG_X_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_FINAL = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_FIRST = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_FINAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_Z_FIRST = 3'd4;
    localparam logic [IDX_W-1:0] REG_Z_FINAL = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [SZ_W-1:0]   sx;
        logic [TNXW-1:0]   tnx;
        logic [TNXW-1:0]   tny;
        logic [TNZW-1:0]   tnz;
        logic [W_LOG-1:0]  lox;
        logic [W_LOG-1:0]  hix;
        logic [W_LOG-1:0]  loy;
        logic [W_LOG-1:0]  hiy;
        logic [D_LOG-1:0]  loz;
        logic [D_LOG-1:0]  hiz;
        logic [ADDR_W-1:0] plane;
        logic [RANK_W-1:0] txy;
        logic              bad;
    } t_drv;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic [TXW-1:0]    tx;
        logic [TXW-1:0]    ty;
        logic [TZW-1:0]    tz;
        logic [W_LOG-1:0]  vx;
        logic [W_LOG-1:0]  vy;
        logic [D_LOG-1:0]  vz;
    } t_step;

    function automatic logic tile_end_w(input logic [TXW-1:0] t, input logic [TNXW-1:0] tn);
        return ({1'b0, t} + TNXW'(1)) >= tn;
    endfunction

    function automatic logic tile_end_d(input logic [TZW-1:0] t, input logic [TNZW-1:0] tn);
        return ({1'b0, t} + TNZW'(1)) >= tn;
    endfunction

endpackage

FILE: rtl/tvr_cfg.sv
`timescale 1ns / 1ps
module tvr_cfg import tvr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CW-1:0]    i_cfg_data,
    output logic             o_cfg_ready,
    output t_drv             o_drv,
    output logic             o_busy
);

    logic [CW-1:0] r_x_first, r_x_final, r_y_first, r_y_final, r_z_first, r_z_final;
    logic [CNT_W-1:0] r_settle;

    logic [SZ_W-1:0]  r_sx, r_sy, r_sz;
    logic [TNXW-1:0]  r_tnx, r_tny;
    logic [TNZW-1:0]  r_tnz;
    logic [W_LOG-1:0] r_lox, r_hix, r_loy, r_hiy;
    logic [D_LOG-1:0] r_loz, r_hiz;
    logic             r_order_bad;

    logic [SXY_W-1:0] r_sxy;
    logic [TXY_W-1:0] r_txy;

    logic [VOX_W-1:0] r_vox;
    logic [TIL_W-1:0] r_tiles;
    logic             r_vox_big;

    logic             r_bad;
    logic             w_cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid & o_cfg_ready;
    assign o_busy      = (r_settle != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_first <= '0;
            r_x_final <= '0;
            r_y_first <= '0;
            r_y_final <= '0;
            r_z_first <= '0;
            r_z_final <= '0;
            r_settle  <= CNT_W'(SETTLE);
        end else begin
            if (w_cfg_fire) begin
                case (i_cfg_index)
                    REG_X_FIRST: r_x_first <= i_cfg_data;
                    REG_X_FINAL: r_x_final <= i_cfg_data;
                    REG_Y_FIRST: r_y_first <= i_cfg_data;
                    REG_Y_FINAL: r_y_final <= i_cfg_data;
                    REG_Z_FIRST: r_z_first <= i_cfg_data;
                    REG_Z_FINAL: r_z_final <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= CNT_W'(SETTLE);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx  <= SZ_W'(r_x_final) - SZ_W'(r_x_first) + SZ_W'(1);
        r_sy  <= SZ_W'(r_y_final) - SZ_W'(r_y_first) + SZ_W'(1);
        r_sz  <= SZ_W'(r_z_final) - SZ_W'(r_z_first) + SZ_W'(1);
        r_tnx <= TNXW'(r_x_final[CW-1:W_LOG]) - TNXW'(r_x_first[CW-1:W_LOG]) + TNXW'(1);
        r_tny <= TNXW'(r_y_final[CW-1:W_LOG]) - TNXW'(r_y_first[CW-1:W_LOG]) + TNXW'(1);
        r_tnz <= TNZW'(r_z_final[CW-1:D_LOG]) - TNZW'(r_z_first[CW-1:D_LOG]) + TNZW'(1);
        r_lox <= r_x_first[W_LOG-1:0];
        r_hix <= r_x_final[W_LOG-1:0];
        r_loy <= r_y_first[W_LOG-1:0];
        r_hiy <= r_y_final[W_LOG-1:0];
        r_loz <= r_z_first[D_LOG-1:0];
        r_hiz <= r_z_final[D_LOG-1:0];
        r_order_bad <= (r_x_first > r_x_final) || (r_y_first > r_y_final) ||
                       (r_z_first > r_z_final);

        r_sxy <= SXY_W'(r_sx) * SXY_W'(r_sy);
        r_txy <= TXY_W'(r_tnx) * TXY_W'(r_tny);

        r_vox_big <= r_sxy > SXY_W'(VOX_LIMIT);
        r_vox     <= VOX_W'(r_sxy[ADDR_W:0]) * VOX_W'(r_sz);
        r_tiles   <= TIL_W'(r_txy) * TIL_W'(r_tnz);

        r_bad <= r_order_bad || r_vox_big || (r_vox > VOX_W'(VOX_LIMIT)) ||
                 (r_tiles > TIL_W'(MAX_TILES));
    end

    always_comb begin
        o_drv.sx    = r_sx;
        o_drv.tnx   = r_tnx;
        o_drv.tny   = r_tny;
        o_drv.tnz   = r_tnz;
        o_drv.lox   = r_lox;
        o_drv.hix   = r_hix;
        o_drv.loy   = r_loy;
        o_drv.hiy   = r_hiy;
        o_drv.loz   = r_loz;
        o_drv.hiz   = r_hiz;
        o_drv.plane = r_sxy[ADDR_W-1:0];
        o_drv.txy   = r_txy[RANK_W-1:0];
        o_drv.bad   = r_bad;
    end

`ifndef NO_ASSERTIONS
    a_write_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_fire |=> o_busy)
        else $error("config write did not hold off transactions");
`endif

endmodule

FILE: rtl/tvr_walk.sv
`timescale 1ns / 1ps
module tvr_walk import tvr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  logic  i_restart,
    input  t_drv  i_drv,
    output t_step o_step
);

    logic [TXW-1:0]   r_tx, r_ty, n_tx, n_ty;
    logic [TZW-1:0]   r_tz, n_tz;
    logic [W_LOG-1:0] r_vx, r_vy, n_vx, n_vy;
    logic [D_LOG-1:0] r_vz, n_vz;
    logic             r_done, n_done;

    logic [STAT_W-1:0] w_stat;
    logic              w_x_end, w_y_end, w_z_end;
    logic [W_LOG-1:0]  w_hi_x, w_hi_y, w_lo_x, w_lo_y;
    logic [D_LOG-1:0]  w_hi_z;
    logic              w_tile_adv, w_fin;

    always_comb begin
        w_x_end = tile_end_w(r_tx, i_drv.tnx);
        w_y_end = tile_end_w(r_ty, i_drv.tny);
        w_z_end = tile_end_d(r_tz, i_drv.tnz);
        w_hi_x  = w_x_end ? i_drv.hix : '1;
        w_hi_y  = w_y_end ? i_drv.hiy : '1;
        w_hi_z  = w_z_end ? i_drv.hiz : '1;
        w_lo_x  = (r_tx == '0) ? i_drv.lox : '0;
        w_lo_y  = (r_ty == '0) ? i_drv.loy : '0;

        n_tx = r_tx;
        n_ty = r_ty;
        n_tz = r_tz;
        n_vx = r_vx;
        n_vy = r_vy;
        n_vz = r_vz;
        n_done = r_done;
        w_stat = ST_OK;
        w_tile_adv = 1'b0;
        w_fin = 1'b0;

        if (i_drv.bad) begin
            n_done = 1'b1;
            w_stat = ST_BAD;
        end else if (i_restart) begin
            n_tx = '0;
            n_ty = '0;
            n_tz = '0;
            n_vx = i_drv.lox;
            n_vy = i_drv.loy;
            n_vz = i_drv.loz;
            n_done = 1'b0;
        end else if (r_done) begin
            w_stat = ST_DONE;
        end else if (r_vx < w_hi_x) begin
            n_vx = r_vx + W_LOG'(1);
        end else begin
            n_vx = w_lo_x;
            if (r_vy < w_hi_y) begin
                n_vy = r_vy + W_LOG'(1);
            end else begin
                n_vy = w_lo_y;
                if (r_vz < w_hi_z) begin
                    n_vz = r_vz + D_LOG'(1);
                end else begin
                    w_tile_adv = 1'b1;
                    if (!w_x_end) begin
                        n_tx = r_tx + TXW'(1);
                    end else begin
                        n_tx = '0;
                        if (!w_y_end) begin
                            n_ty = r_ty + TXW'(1);
                        end else begin
                            n_ty = '0;
                            if (!w_z_end) begin
                                n_tz = r_tz + TZW'(1);
                            end else begin
                                w_fin  = 1'b1;
                                n_done = 1'b1;
                                w_stat = ST_DONE;
                            end
                        end
                    end
                end
            end
        end

        if (w_tile_adv && !w_fin) begin
            n_vx = (n_tx == '0) ? i_drv.lox : '0;
            n_vy = (n_ty == '0) ? i_drv.loy : '0;
            n_vz = (n_tz == '0) ? i_drv.loz : '0;
        end

        o_step.stat = w_stat;
        o_step.tx   = n_tx;
        o_step.ty   = n_ty;
        o_step.tz   = n_tz;
        o_step.vx   = n_vx;
        o_step.vy   = n_vy;
        o_step.vz   = n_vz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx   <= '0;
            r_ty   <= '0;
            r_tz   <= '0;
            r_vx   <= '0;
            r_vy   <= '0;
            r_vz   <= '0;
            r_done <= 1'b1;
        end else if (i_fire) begin
            r_tx   <= n_tx;
            r_ty   <= n_ty;
            r_tz   <= n_tz;
            r_vx   <= n_vx;
            r_vy   <= n_vy;
            r_vz   <= n_vz;
            r_done <= n_done;
        end
    end

`ifndef NO_ASSERTIONS
    a_restart_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_restart && !i_drv.bad |=> !r_done)
        else $error("restart with valid bounds left the walk finished");
`endif

endmodule

FILE: rtl/tvr_addr.sv
`timescale 1ns / 1ps
module tvr_addr import tvr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_step             i_step,
    input  t_drv              i_drv,
    output logic              o_rdy,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [RANK_W-1:0] o_tile_rank,
    output logic [OFF_W-1:0]  o_tile_offset,
    output logic [ADDR_W-1:0] o_region_address,
    output logic              o_last,
    output logic [STAT_W-1:0] o_status
);

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic              last;
        logic [SZ_W-1:0]   dx;
        logic [SZ_W-1:0]   dy;
        logic [SZ_W-1:0]   dz;
        logic [OFF_W-1:0]  off;
        logic [RANK_W-1:0] tx;
        logic [RANK_W-1:0] ty;
        logic [RANK_W-1:0] tz;
    } t_pos;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic              last;
        logic [ADDR_W-1:0] pz;
        logic [ADDR_W-1:0] py;
        logic [ADDR_W-1:0] dx;
        logic [OFF_W-1:0]  off;
        logic [RANK_W-1:0] rz;
        logic [RANK_W-1:0] ry;
        logic [RANK_W-1:0] tx;
    } t_prod;

    logic  r_va, r_vb, r_vc, r_vd;
    t_step r_a;
    t_pos  r_b, n_b;
    t_prod r_c, n_c;
    logic  w_rd_b, w_rd_c, w_rd_d;

    logic [W_LOG-1:0] w_hi_x, w_hi_y;
    logic [D_LOG-1:0] w_hi_z;
    logic             w_x_end, w_y_end, w_z_end;
    logic [ADDR_W-1:0] w_dz32, w_dy32, w_addr;
    logic [RANK_W-1:0] w_rank;

    assign w_rd_d = !r_vd || i_out_ready;
    assign w_rd_c = !r_vc || w_rd_d;
    assign w_rd_b = !r_vb || w_rd_c;
    assign o_rdy  = !r_va || w_rd_b;

    always_comb begin
        w_x_end = tile_end_w(r_a.tx, i_drv.tnx);
        w_y_end = tile_end_w(r_a.ty, i_drv.tny);
        w_z_end = tile_end_d(r_a.tz, i_drv.tnz);
        w_hi_x  = w_x_end ? i_drv.hix : '1;
        w_hi_y  = w_y_end ? i_drv.hiy : '1;
        w_hi_z  = w_z_end ? i_drv.hiz : '1;

        n_b.stat = r_a.stat;
        n_b.last = w_x_end && w_y_end && w_z_end && (r_a.vx >= w_hi_x) &&
                   (r_a.vy >= w_hi_y) && (r_a.vz >= w_hi_z);
        n_b.dx   = SZ_W'({r_a.tx, r_a.vx}) - SZ_W'(i_drv.lox);
        n_b.dy   = SZ_W'({r_a.ty, r_a.vy}) - SZ_W'(i_drv.loy);
        n_b.dz   = SZ_W'({r_a.tz, r_a.vz}) - SZ_W'(i_drv.loz);
        n_b.off  = OFF_W'({r_a.vz, r_a.vy, r_a.vx});
        n_b.tx   = RANK_W'(r_a.tx);
        n_b.ty   = RANK_W'(r_a.ty);
        n_b.tz   = RANK_W'(r_a.tz);
    end

    always_comb begin
        w_dz32   = {{(ADDR_W - SZ_W){r_b.dz[SZ_W-1]}}, r_b.dz};
        w_dy32   = {{(ADDR_W - SZ_W){r_b.dy[SZ_W-1]}}, r_b.dy};
        n_c.stat = r_b.stat;
        n_c.last = r_b.last;
        n_c.pz   = w_dz32 * i_drv.plane;
        n_c.py   = w_dy32 * ADDR_W'(i_drv.sx);
        n_c.dx   = {{(ADDR_W - SZ_W){r_b.dx[SZ_W-1]}}, r_b.dx};
        n_c.off  = r_b.off;
        n_c.rz   = r_b.tz * i_drv.txy;
        n_c.ry   = r_b.ty * RANK_W'(i_drv.tnx);
        n_c.tx   = r_b.tx;
    end

    assign w_addr = r_c.pz + r_c.py + r_c.dx;
    assign w_rank = r_c.rz + r_c.ry + r_c.tx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_va <= i_fire;
            end
            if (w_rd_b) begin
                r_vb <= r_va;
            end
            if (w_rd_c) begin
                r_vc <= r_vb;
            end
            if (w_rd_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && o_rdy) begin
            r_a <= i_step;
        end
        if (r_va && w_rd_b) begin
            r_b <= n_b;
        end
        if (r_vb && w_rd_c) begin
            r_c <= n_c;
        end
        if (r_vc && w_rd_d) begin
            o_status <= r_c.stat;
            if (r_c.stat == ST_OK) begin
                o_tile_rank      <= w_rank;
                o_tile_offset    <= r_c.off;
                o_region_address <= w_addr;
                o_last           <= r_c.last;
            end else begin
                o_tile_rank      <= '0;
                o_tile_offset    <= '0;
                o_region_address <= '0;
                o_last           <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_vd;

`ifndef NO_ASSERTIONS
    a_fire_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_va)
        else $error("accepted transaction did not enter the pipeline");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va && r_vb && r_vc && r_vd && !i_out_ready |-> !o_rdy)
        else $error("pipeline full and stalled but still ready");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_tile_rank == '0) && (o_tile_offset == '0) &&
            (o_region_address == '0) && !o_last)
        else $error("non-voxel transaction carries address fields");
`endif

endmodule

FILE: rtl/tiled_volume_roi_gather_address_unit.sv
`timescale 1ns / 1ps
// Gather address generator for a 3D region of interest in a volume stored as
// 256 x 256 x 64 voxel tiles. Write the six inclusive bounds, then send a
// transaction with restart set to emit the first voxel; each further
// transaction with restart clear emits the next voxel, walking tiles z, y, x
// and the clipped voxels of each tile z, y, x. Every transaction returns one
// result: tile rank, offset inside the tile, region buffer address, last mark
// and status (voxel, walk finished, or bad bounds). One transaction is taken
// per clock unless the output stalls or config is settling; a result passes
// the step, position, multiply and sum registers before it is presented.
// After reset and after each config write, input ready stays low while the
// config pipeline recomputes region size, tile counts and the bounds check.
module tiled_volume_roi_gather_address_unit import tvr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CW-1:0]     i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_restart,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [RANK_W-1:0] o_tile_rank,
    output logic [OFF_W-1:0]  o_tile_offset,
    output logic [ADDR_W-1:0] o_region_address,
    output logic              o_last,
    output logic [STAT_W-1:0] o_status
);

    t_drv  w_drv;
    t_step w_step;
    logic  w_busy, w_rdy, w_fire;

    assign o_in_ready = w_rdy && !w_busy;
    assign w_fire     = i_in_valid && o_in_ready;

    tvr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_drv       (w_drv),
        .o_busy      (w_busy)
    );

    tvr_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_restart (i_restart),
        .i_drv     (w_drv),
        .o_step    (w_step)
    );

    tvr_addr u_addr (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_step           (w_step),
        .i_drv            (w_drv),
        .o_rdy            (w_rdy),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tile_rank      (o_tile_rank),
        .o_tile_offset    (o_tile_offset),
        .o_region_address (o_region_address),
        .o_last           (o_last),
        .o_status         (o_status)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tvr_pkg::*;

    localparam int unsigned BLK_W = 1 << W_LOG;
    localparam int unsigned BLK_D = 1 << D_LOG;
    localparam int unsigned VMAX = (1 << CW) - 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [OFF_W-1:0]  offset;
        logic [ADDR_W-1:0] addr;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_voxel_res;

    typedef struct packed {
        int unsigned start;
        int unsigned stop;
        int unsigned span;
        int unsigned tiles;
    } t_axis_span;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_MASKED} t_rx_mode;
    typedef enum logic [1:0] {PH_WALK, PH_RETARGET, PH_WIDE, PH_NOISE} t_phase;

    class roi_address_checker;
        int unsigned bound[6];
        int unsigned tile_x, tile_y, tile_z, vox_x, vox_y, vox_z;
        bit walk_done = 1'b1;
        t_voxel_res expected_voxels[$];
        int errors;

        function void write_bound(logic [IDX_W-1:0] idx, logic [CW-1:0] val);
            if (idx <= REG_Z_FINAL) begin
                bound[idx] = val;
            end
        endfunction

        function t_axis_span span_of(int unsigned start, int unsigned stop, int unsigned bs);
            t_axis_span a;
            a.start = start;
            a.stop = stop;
            a.span = (stop >= start) ? stop - start + 1 : 0;
            a.tiles = (stop >= start) ? stop / bs - start / bs + 1 : 0;
            return a;
        endfunction

        function int unsigned lo_at(t_axis_span a, int unsigned t, int unsigned bs);
            return (t == 0) ? a.start % bs : 0;
        endfunction

        function int unsigned hi_at(t_axis_span a, int unsigned t, int unsigned bs);
            return (t + 1 >= a.tiles) ? a.stop % bs : bs - 1;
        endfunction

        function void first_voxel(t_axis_span ax, t_axis_span ay, t_axis_span az);
            vox_x = lo_at(ax, tile_x, BLK_W);
            vox_y = lo_at(ay, tile_y, BLK_W);
            vox_z = lo_at(az, tile_z, BLK_D);
        endfunction

        // carry x -> y -> z inside the tile, then tile x -> y -> z
        function bit advance_walk(t_axis_span ax, t_axis_span ay, t_axis_span az);
            if (vox_x < hi_at(ax, tile_x, BLK_W)) begin
                vox_x++;
            end else begin
                vox_x = lo_at(ax, tile_x, BLK_W);
                if (vox_y < hi_at(ay, tile_y, BLK_W)) begin
                    vox_y++;
                end else begin
                    vox_y = lo_at(ay, tile_y, BLK_W);
                    if (vox_z < hi_at(az, tile_z, BLK_D)) begin
                        vox_z++;
                    end else begin
                        if (tile_x + 1 < ax.tiles) begin
                            tile_x++;
                        end else begin
                            tile_x = 0;
                            if (tile_y + 1 < ay.tiles) begin
                                tile_y++;
                            end else begin
                                tile_y = 0;
                                if (tile_z + 1 < az.tiles) begin
                                    tile_z++;
                                end else begin
                                    return 1'b0;
                                end
                            end
                        end
                        first_voxel(ax, ay, az);
                    end
                end
            end
            return 1'b1;
        endfunction

        function t_voxel_res voxel_at(t_axis_span ax, t_axis_span ay, t_axis_span az);
            t_voxel_res r;
            int unsigned xd, yd, zd;
            xd = tile_x * BLK_W + vox_x - ax.start % BLK_W;
            yd = tile_y * BLK_W + vox_y - ay.start % BLK_W;
            zd = tile_z * BLK_D + vox_z - az.start % BLK_D;
            r.rank = RANK_W'((tile_z * ay.tiles + tile_y) * ax.tiles + tile_x);
            r.offset = OFF_W'((vox_z * BLK_W + vox_y) * BLK_W + vox_x);
            r.addr = (zd * ay.span + yd) * ax.span + xd;
            r.last = (tile_x + 1 >= ax.tiles) && (tile_y + 1 >= ay.tiles) &&
                     (tile_z + 1 >= az.tiles) &&
                     (vox_x >= hi_at(ax, tile_x, BLK_W)) &&
                     (vox_y >= hi_at(ay, tile_y, BLK_W)) &&
                     (vox_z >= hi_at(az, tile_z, BLK_D));
            r.status = ST_OK;
            return r;
        endfunction

        function void predict_voxel(bit restart);
            t_axis_span ax, ay, az;
            longint unsigned tile_total, voxel_total;
            t_voxel_res r;
            ax = span_of(bound[REG_X_FIRST], bound[REG_X_FINAL], BLK_W);
            ay = span_of(bound[REG_Y_FIRST], bound[REG_Y_FINAL], BLK_W);
            az = span_of(bound[REG_Z_FIRST], bound[REG_Z_FINAL], BLK_D);
            tile_total = 64'(ax.tiles) * 64'(ay.tiles) * 64'(az.tiles);
            voxel_total = 64'(ax.span) * 64'(ay.span) * 64'(az.span);
            r = '0;
            if (ax.span == 0 || ay.span == 0 || az.span == 0 ||
                tile_total > 64'(MAX_TILES) || voxel_total > 64'h1_0000_0000) begin
                walk_done = 1'b1;
                r.status = ST_BAD;
            end else if (restart) begin
                tile_x = 0;
                tile_y = 0;
                tile_z = 0;
                first_voxel(ax, ay, az);
                walk_done = 1'b0;
                r = voxel_at(ax, ay, az);
            end else if (walk_done) begin
                r.status = ST_DONE;
            end else if (advance_walk(ax, ay, az)) begin
                r = voxel_at(ax, ay, az);
            end else begin
                walk_done = 1'b1;
                r.status = ST_DONE;
            end
            expected_voxels = {expected_voxels, r};
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        task check_voxel(t_voxel_res got);
            t_voxel_res want;
            if (expected_voxels.size() == 0) begin
                report($sformatf("unexpected result, status %0d", got.status));
                return;
            end
            want = expected_voxels.pop_front();
            if (got.rank !== want.rank)
                report($sformatf("tile_rank %0h, want %0h", got.rank, want.rank));
            if (got.offset !== want.offset)
                report($sformatf("tile_offset %0h, want %0h", got.offset, want.offset));
            if (got.addr !== want.addr)
                report($sformatf("region_address %0h, want %0h", got.addr, want.addr));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = REG_X_FIRST;
    logic [CW-1:0]     i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              i_restart = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [RANK_W-1:0] o_tile_rank;
    logic [OFF_W-1:0]  o_tile_offset;
    logic [ADDR_W-1:0] o_region_address;
    logic              o_last;
    logic [STAT_W-1:0] o_status;

    roi_address_checker addr_check = new;
    t_voxel_res seen;
    int unsigned roi[6];
    int items_sent;
    int burst_left;
    bit offering;
    int hold_asked;
    int hold_served;
    int hold_left;
    int rx_tick;
    t_rx_mode rx_mode = RX_OPEN;
    logic [7:0] rx_mask = 8'hff;
    int cycle_count;

    tiled_volume_roi_gather_address_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_restart(i_restart),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_tile_rank(o_tile_rank),
        .o_tile_offset(o_tile_offset),
        .o_region_address(o_region_address),
        .o_last(o_last),
        .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.rank = o_tile_rank;
            seen.offset = o_tile_offset;
            seen.addr = o_region_address;
            seen.last = o_last;
            seen.status = o_status;
            addr_check.check_voxel(seen);
        end
        rx_tick++;
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_tick % 40 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mask = 8'($urandom_range(1, 255));
            end
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
                default:   i_out_ready <= rx_mask[rx_tick % 8];
            endcase
        end
    end

    function automatic void pick_span(input int unsigned bs, output int unsigned lo,
                                      output int unsigned hi);
        int unsigned k;
        int unsigned sel;
        k = $urandom_range(1, (1 << CW) / bs - 1);
        sel = $urandom_range(0, 15);
        if (sel < 9) begin
            lo = k * bs - $urandom_range(0, 2);
            hi = lo + $urandom_range(0, 3);
        end else if (sel < 12) begin
            lo = $urandom_range(0, VMAX - 3);
            hi = lo + $urandom_range(0, 3);
        end else if (sel == 12) begin
            hi = VMAX;
            lo = hi - $urandom_range(0, 3);
        end else if (sel == 13) begin
            lo = $urandom_range(0, 3);
            hi = lo + $urandom_range(0, 2);
        end else if (sel == 14) begin
            lo = k * bs - 1;
            hi = lo + bs;
        end else begin
            lo = $urandom_range(1, VMAX);
            hi = $urandom_range(0, lo - 1);
        end
    endfunction

    function automatic int walk_steps();
        longint unsigned n;
        n = 1;
        for (int a = 0; a < 3; a++) begin
            if (roi[2 * a + 1] < roi[2 * a]) return 1;
            n = n * (roi[2 * a + 1] - roi[2 * a] + 1);
        end
        if (n > 40) return 40;
        return int'(n) + $urandom_range(0, 2);
    endfunction

    task automatic send_item(input bit restart);
        int gap;
        i_in_valid <= 1'b1;
        i_restart <= restart;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        addr_check.predict_voxel(restart);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(1, 8);
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic continue_walk(input int n);
        repeat (n) send_item($urandom_range(0, 31) == 0);
    endtask

    task automatic walk(input int n);
        send_item(1'b1);
        continue_walk(n);
    endtask

    task automatic drain();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge i_clk); while (addr_check.expected_voxels.size() != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CW'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        addr_check.write_bound(idx, CW'(val));
        if (idx <= REG_Z_FINAL) roi[idx] = val;
    endtask

    task automatic set_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
        drain();
        write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_region(input int unsigned xf, xl, yf, yl, zf, zl);
        drain();
        write_reg(REG_X_FIRST, xf);
        write_reg(REG_X_FINAL, xl);
        write_reg(REG_Y_FIRST, yf);
        write_reg(REG_Y_FINAL, yl);
        write_reg(REG_Z_FIRST, zf);
        write_reg(REG_Z_FINAL, zl);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_region();
        int unsigned xf, xl, yf, yl, zf, zl;
        pick_span(BLK_W, xf, xl);
        pick_span(BLK_W, yf, yl);
        pick_span(BLK_D, zf, zl);
        program_region(xf, xl, yf, yl, zf, zl);
    endtask

    initial begin
        int random_base;
        int phase_no;
        t_phase kind;
        int unsigned lo, hi, axis;
        logic [IDX_W-1:0] reg_lo, reg_hi;
        bit squeeze;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle after reset, then the one-voxel reset region
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        // tile boundary on every axis
        program_region(255, 256, 255, 256, 63, 64);
        walk(8);
        program_region(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX);
        walk(1);
        // largest legal region: full tile budget, exactly 2^32 voxels
        program_region(0, VMAX, 0, 255, 0, 15);
        walk(2);
        set_reg(REG_Z_FINAL, 63);
        send_item(1'b0);
        program_region(5, 4, 0, 0, 0, 0);
        send_item(1'b1);
        program_region(0, VMAX, 0, 256, 0, 0);
        send_item(1'b0);
        // bounds moved during a walk, plus writes to unused indexes
        program_region(10, 12, 0, 0, 0, 0);
        walk(1);
        set_reg(REG_X_FINAL, 300);
        set_reg(REG_SPARE_A, VMAX);
        set_reg(REG_SPARE_B, 0);
        send_item(1'b0);
        send_item(1'b0);

        random_base = items_sent;
        phase_no = 0;
        while (items_sent < random_base + RANDOM_ITEMS) begin
            lo = $urandom_range(0, 9);
            kind = (lo < 7) ? PH_WALK : (lo == 7) ? PH_RETARGET : (lo == 8) ? PH_WIDE :
                   PH_NOISE;
            if (phase_no == 0) kind = PH_WIDE;
            case (kind)
                PH_WALK: begin
                    random_region();
                    walk(walk_steps());
                end
                PH_RETARGET: begin
                    random_region();
                    walk($urandom_range(1, 4));
                    drain();
                    axis = $urandom_range(0, 2);
                    reg_lo = (axis == 0) ? REG_X_FIRST : (axis == 1) ? REG_Y_FIRST :
                             REG_Z_FIRST;
                    reg_hi = (axis == 0) ? REG_X_FINAL : (axis == 1) ? REG_Y_FINAL :
                             REG_Z_FINAL;
                    pick_span((axis == 2) ? BLK_D : BLK_W, lo, hi);
                    write_reg(reg_lo, lo);
                    write_reg(reg_hi, hi);
                    i_cfg_valid <= 1'b0;
                    continue_walk(walk_steps() + 2);
                end
                PH_WIDE: begin
                    squeeze = (phase_no == 0) || ($urandom_range(0, 3) == 0);
                    if (squeeze) begin
                        program_region($urandom_range(0, 600), VMAX - $urandom_range(0, 600),
                                       0, 0, 0, 0);
                        hold_asked++;
                        burst_left = 60;
                    end else begin
                        pick_span(BLK_W, lo, hi);
                        program_region($urandom_range(0, 600), VMAX - $urandom_range(0, 600),
                                       lo, hi, roi[REG_Z_FIRST], roi[REG_Z_FIRST]);
                    end
                    walk(40);
                end
                default: begin
                    program_region($urandom_range(0, VMAX), $urandom_range(0, VMAX),
                                   $urandom_range(0, VMAX), $urandom_range(0, VMAX),
                                   $urandom_range(0, VMAX), $urandom_range(0, VMAX));
                    repeat (6) send_item(1'($urandom_range(0, 1)));
                end
            endcase
            phase_no++;
        end

        drain();
        repeat (4 * SETTLE) @(posedge i_clk);
        if (addr_check.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tvr_pkg.sv
rtl/tvr_cfg.sv
rtl/tvr_walk.sv
rtl/tvr_addr.sv
rtl/tiled_volume_roi_gather_address_unit.sv
tb/tb_top.sv
